>>> rtl/core/trpq_pkg.sv
`timescale 1ns / 1ps

package trpq_pkg;

  localparam int unsigned NumSlots  = 5;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [7:0] PollRestart   = 8'd10;
  localparam logic [7:0] PollCeiling   = 8'd240;
  localparam logic [7:0] PollDivTen    = 8'd10;
  localparam logic [7:0] DivTenMul     = 8'd205;
  localparam int unsigned DivTenShift  = 11;

  localparam logic [7:0] ReadyBit      = 8'h80;
  localparam logic [7:0] ReleaseMask   = 8'h8F;
  localparam logic [7:0] ReleaseMode   = 8'h80;
  localparam logic [7:0] CapturedFlags = 8'hC0;
  localparam logic [7:0] KeepHighFlags = 8'hE0;
  localparam logic [7:0] DropPressed   = 8'h7F;
  localparam logic [CoordW-1:0] NoPoint = 16'hFFFF;

  localparam logic [CoordW-1:0] LimitXReset = 16'd320;
  localparam logic [CoordW-1:0] LimitYReset = 16'd480;
  localparam logic [CoordW-1:0] ShortReset  = 16'd320;
  localparam logic [CoordW-1:0] LongReset   = 16'd480;

  typedef enum logic [1:0] {
    OrientNative = 2'd0,
    OrientFlip   = 2'd1,
    OrientSwapA  = 2'd2,
    OrientSwapB  = 2'd3
  } trpq_orient_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOrientation = 3'd0,
    CfgLimitX      = 3'd1,
    CfgLimitY      = 3'd2,
    CfgShortExtent = 3'd3,
    CfgLongExtent  = 3'd4
  } trpq_cfg_idx_e;

  typedef struct packed {
    logic [7:0]  caller_mode;
    logic [7:0]  status_byte;
    logic [31:0] raw_point_0;
    logic [31:0] raw_point_1;
    logic [31:0] raw_point_2;
    logic [31:0] raw_point_3;
    logic [31:0] raw_point_4;
  } trpq_in_t;

  typedef struct packed {
    logic        new_touch;
    logic        polled;
    logic        clear_status;
    logic [7:0]  touch_state;
    logic [31:0] point_0;
    logic [31:0] point_1;
    logic [31:0] point_2;
    logic [31:0] point_3;
    logic [31:0] point_4;
  } trpq_out_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } trpq_point_t;

  typedef struct packed {
    trpq_orient_e      orientation;
    logic [CoordW-1:0] limit_x;
    logic [CoordW-1:0] limit_y;
    logic [CoordW-1:0] short_extent;
    logic [CoordW-1:0] long_extent;
  } trpq_cfg_t;

  typedef struct packed {
    logic [7:0]                     poll_count;
    logic [7:0]                     flags;
    trpq_point_t [NumSlots-1:0]     pts;
  } trpq_state_t;

  typedef struct packed {
    logic new_touch;
    logic polled;
    logic clear_status;
  } trpq_status_t;

endpackage

>>> rtl/core/trpq_lane.sv
`timescale 1ns / 1ps

module trpq_lane import trpq_pkg::*; (
  input  trpq_orient_e      orient_i,
  input  logic [CoordW-1:0] short_extent_i,
  input  logic [CoordW-1:0] long_extent_i,
  input  logic [31:0]       raw_i,
  output trpq_point_t       pt_o
);

  logic [CoordW-1:0] a;
  logic [CoordW-1:0] b;

  assign a = raw_i[15:0];
  assign b = raw_i[31:16];

  // rotate the record for the panel orientation, wrapping mod 2^16
  always_comb begin
    unique case (orient_i)
      OrientNative: begin
        pt_o.x = a;
        pt_o.y = b;
      end
      OrientFlip: begin
        pt_o.x = short_extent_i - a;
        pt_o.y = long_extent_i - b;
      end
      OrientSwapA: begin
        pt_o.x = b;
        pt_o.y = short_extent_i - a;
      end
      default: begin
        pt_o.x = long_extent_i - b;
        pt_o.y = a;
      end
    endcase
  end

endmodule

>>> rtl/core/trpq_merge.sv
`timescale 1ns / 1ps

module trpq_merge import trpq_pkg::*; #(
  parameter int unsigned MAX_POINTS = 5
) (
  input  trpq_cfg_t                cfg_i,
  input  trpq_in_t                 item_i,
  input  trpq_state_t              cur_i,
  input  trpq_point_t [NumSlots-1:0] lane_pt_i,
  output trpq_state_t              nxt_o,
  output trpq_status_t             status_o
);

  logic [7:0]  pc_inc;
  logic [15:0] div_prod;
  logic [4:0]  div_quot;
  logic [7:0]  quot_x10;
  logic        is_mult10;
  logic        poll;
  logic [3:0]  cnt;
  logic        cnt_ok;
  logic        touch;
  logic [7:0]  mode;
  logic [7:0]  mark_mask;

  assign pc_inc    = cur_i.poll_count + 8'd1;
  assign div_prod  = {8'd0, pc_inc} * {8'd0, DivTenMul};
  assign div_quot  = div_prod[DivTenShift +: 5];
  assign quot_x10  = {div_quot, 3'd0} + {2'd0, div_quot, 1'd0};
  assign is_mult10 = (quot_x10 == pc_inc);
  assign poll      = is_mult10 || (pc_inc < PollDivTen);
  assign cnt       = item_i.status_byte[3:0];
  assign cnt_ok    = (cnt <= 4'(MAX_POINTS));
  assign touch     = poll && (cnt != 4'd0) && cnt_ok;
  assign mark_mask = 8'((9'd1 << cnt) - 9'd1);

  always_comb begin
    nxt_o                 = cur_i;
    nxt_o.poll_count      = pc_inc;
    status_o.new_touch    = touch;
    status_o.polled       = poll;
    status_o.clear_status = poll && ((item_i.status_byte & ReadyBit) != 8'd0) && cnt_ok;
    mode                  = poll ? item_i.status_byte : item_i.caller_mode;

    if (touch) begin
      nxt_o.flags   = mark_mask | CapturedFlags;
      nxt_o.pts[4]  = cur_i.pts[0];
      for (int k = 0; k < NumSlots; k++) begin
        if (4'(k) < cnt) begin
          nxt_o.pts[k] = lane_pt_i[k];
        end
      end
      if ((nxt_o.pts[0].x > cfg_i.limit_x) || (nxt_o.pts[0].y > cfg_i.limit_y)) begin
        if (cnt > 4'd1) begin
          nxt_o.pts[0]     = lane_pt_i[1];
          nxt_o.poll_count = 8'd0;
        end else begin
          // restore the previous point and treat as a release
          nxt_o.pts[0] = cur_i.pts[0];
          mode         = ReleaseMode;
          nxt_o.flags  = cur_i.flags;
        end
      end else begin
        nxt_o.poll_count = 8'd0;
      end
    end

    if ((mode & ReleaseMask) == ReleaseMode) begin
      if ((nxt_o.flags & ReadyBit) != 8'd0) begin
        nxt_o.flags = nxt_o.flags & DropPressed;
      end else begin
        nxt_o.pts[0].x = NoPoint;
        nxt_o.pts[0].y = NoPoint;
        nxt_o.flags    = nxt_o.flags & KeepHighFlags;
      end
    end

    if (nxt_o.poll_count > PollCeiling) begin
      nxt_o.poll_count = PollRestart;
    end
  end

endmodule

>>> rtl/core/touch_report_point_qualifier_unit.sv
`timescale 1ns / 1ps
// A result is registered in out_q when the output is free, else in skid_q.
// Throughput: one transaction per cycle while in_stall_o is low; the five point
// lanes and the merge stage are combinational; the state update is registered.
// A two-entry output buffer keeps the input open while one result is stalled.
// Reset (rst_ni low, asynchronous): poll counter, flags and points clear to zero,
// configuration returns to orientation 0, limits 320/480, extents 320/480.

module touch_report_point_qualifier_unit import trpq_pkg::*; #(
  parameter int unsigned MAX_POINTS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trpq_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trpq_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  trpq_cfg_t                  cfg_q;
  trpq_state_t                state_q;
  trpq_state_t                state_d;
  trpq_status_t               status;
  trpq_point_t [NumSlots-1:0] lane_pt;
  logic [NumSlots-1:0][31:0]  raw_pts;
  trpq_out_t                  result;
  trpq_out_t                  out_q;
  trpq_out_t                  skid_q;
  logic                       out_valid_q;
  logic                       skid_valid_q;
  logic                       accept;
  logic                       out_free;

  assign raw_pts[0] = in_data_i.raw_point_0;
  assign raw_pts[1] = in_data_i.raw_point_1;
  assign raw_pts[2] = in_data_i.raw_point_2;
  assign raw_pts[3] = in_data_i.raw_point_3;
  assign raw_pts[4] = in_data_i.raw_point_4;

  for (genvar k = 0; k < NumSlots; k++) begin : g_lane
    if (k < MAX_POINTS) begin : g_used
      trpq_lane u_lane (
        .orient_i       (cfg_q.orientation),
        .short_extent_i (cfg_q.short_extent),
        .long_extent_i  (cfg_q.long_extent),
        .raw_i          (raw_pts[k]),
        .pt_o           (lane_pt[k])
      );
    end else begin : g_unused
      assign lane_pt[k] = '0;
    end
  end

  trpq_merge #(
    .MAX_POINTS (MAX_POINTS)
  ) u_merge (
    .cfg_i     (cfg_q),
    .item_i    (in_data_i),
    .cur_i     (state_q),
    .lane_pt_i (lane_pt),
    .nxt_o     (state_d),
    .status_o  (status)
  );

  assign result.new_touch    = status.new_touch;
  assign result.polled       = status.polled;
  assign result.clear_status = status.clear_status;
  assign result.touch_state  = state_d.flags;
  assign result.point_0      = state_d.pts[0];
  assign result.point_1      = state_d.pts[1];
  assign result.point_2      = state_d.pts[2];
  assign result.point_3      = state_d.pts[3];
  assign result.point_4      = state_d.pts[4];

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation  <= OrientNative;
      cfg_q.limit_x      <= LimitXReset;
      cfg_q.limit_y      <= LimitYReset;
      cfg_q.short_extent <= ShortReset;
      cfg_q.long_extent  <= LongReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOrientation: cfg_q.orientation  <= trpq_orient_e'(cfg_wdata_i[1:0]);
        CfgLimitX:      cfg_q.limit_x      <= cfg_wdata_i;
        CfgLimitY:      cfg_q.limit_y      <= cfg_wdata_i;
        CfgShortExtent: cfg_q.short_extent <= cfg_wdata_i;
        CfgLongExtent:  cfg_q.long_extent  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // advance the payload alongside the valid flags
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

`ifndef SYNTH
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_poll_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.poll_count <= PollCeiling)
    else $error("poll counter above ceiling");

  a_accept_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !out_valid_q) |=> out_valid_q)
    else $error("accepted transaction not presented");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled while output was free");
`endif

endmodule
